// File: hw/rtl/psg_tone_noise_generator_assert.svh
// ----------------------------------------------------------------------------
// PSG assertion macros
// Concurrent assertion helpers shared by the tone/noise generator modules.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// PSG package
// Widths, register codes and shared types of the tone/noise generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int NumChan = 4;
  localparam int NumTone = 3;
  localparam int PeriodW = 10;
  localparam int AttenW  = 4;
  localparam int CountW  = 14;
  localparam int LfsrW   = 16;

  // Byte write decode
  localparam logic [7:0] WritePort = 8'h7F;
  localparam int         LatchBit  = 7;
  localparam int         TypeBit   = 4;

  // Noise control word (period register of the noise channel)
  localparam int         WhiteBit  = 2;
  localparam logic [1:0] RateTone2 = 2'b11;

  typedef enum logic {
    OpTick  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef logic [PeriodW-1:0] period_t;
  typedef logic [AttenW-1:0]  atten_t;
  typedef logic [CountW-1:0]  count_t;

  // Noise base step is 256 ticks, doubled per rate code
  localparam count_t NoiseBase = count_t'(256);

  // One byte write handed to the register file
  typedef struct packed {
    logic       en;
    logic [7:0] port;
    logic [7:0] data;
  } wr_req_t;

endpackage

// File: hw/rtl/psg_in_if.sv
// ----------------------------------------------------------------------------
// PSG input channel
// Valid/ready channel carrying one tick or byte-write beat.
// ----------------------------------------------------------------------------
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] port_address;
  logic [7:0] write_byte;

  modport source (output valid, output operation, output port_address,
                  output write_byte, input ready);
  modport sink   (input valid, input operation, input port_address,
                  input write_byte, output ready);
endinterface

// File: hw/rtl/psg_out_if.sv
// ----------------------------------------------------------------------------
// PSG output channel
// Valid/ready channel carrying the phases and attenuations of all channels.
// ----------------------------------------------------------------------------
interface psg_out_if;
  logic       valid;
  logic       ready;
  logic       tone0_phase;
  logic       tone1_phase;
  logic       tone2_phase;
  logic       noise_phase;
  logic [3:0] tone0_atten;
  logic [3:0] tone1_atten;
  logic [3:0] tone2_atten;
  logic [3:0] noise_atten;

  modport source (output valid, output tone0_phase, output tone1_phase,
                  output tone2_phase, output noise_phase, output tone0_atten,
                  output tone1_atten, output tone2_atten, output noise_atten,
                  input ready);
  modport sink   (input valid, input tone0_phase, input tone1_phase,
                  input tone2_phase, input noise_phase, input tone0_atten,
                  input tone1_atten, input tone2_atten, input noise_atten,
                  output ready);
endinterface

// File: hw/rtl/psg_regs.sv
// ----------------------------------------------------------------------------
// PSG register file
// Latch/data byte decode, period and attenuation registers.
// ----------------------------------------------------------------------------
module psg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psg_pkg::wr_req_t  wr_i,
  output psg_pkg::period_t  period_o [psg_pkg::NumChan],
  output psg_pkg::atten_t   atten_o  [psg_pkg::NumChan]
);
  import psg_pkg::*;

  period_t    period_q [NumChan];
  period_t    period_d [NumChan];
  atten_t     atten_q  [NumChan];
  atten_t     atten_d  [NumChan];
  logic [7:0] latch_q, latch_d;
  logic [1:0] ch;
  logic       on_port;

  // Byte decode
  always_comb begin
    period_d = period_q;
    atten_d  = atten_q;
    latch_d  = latch_q;
    on_port  = (wr_i.port == WritePort);
    ch       = wr_i.data[6:5];
    if (wr_i.en) begin
      if (wr_i.data[LatchBit]) begin
        // latch byte: low nibble of period or attenuation
        if (on_port) begin
          if (!wr_i.data[TypeBit]) begin
            period_d[ch][3:0] = wr_i.data[3:0];
          end else begin
            atten_d[ch] = wr_i.data[3:0];
          end
        end
        latch_d = wr_i.data;
      end else begin
        // data byte: upper six period bits of the latched channel
        ch = latch_q[6:5];
        if (on_port && !latch_q[TypeBit]) begin
          period_d[ch][9:4] = wr_i.data[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        period_q[i] <= '0;
        atten_q[i]  <= '0;
      end
      latch_q <= '0;
    end else begin
      period_q <= period_d;
      atten_q  <= atten_d;
      latch_q  <= latch_d;
    end
  end

  assign period_o = period_q;
  assign atten_o  = atten_q;

endmodule

// File: hw/rtl/psg_tone.sv
// ----------------------------------------------------------------------------
// PSG tone channel
// Tick counter and square-wave phase of one tone channel.
// ----------------------------------------------------------------------------
module psg_tone (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  psg_pkg::period_t period_i,
  output logic             phase_o
);
  import psg_pkg::*;

  count_t count_q, count_d;
  count_t count_inc;
  logic   phase_q, phase_d;

  // Count up; wrap to zero and toggle at period*16
  always_comb begin
    count_inc = count_q + count_t'(1);
    count_d   = count_q;
    phase_d   = phase_q;
    if (tick_i) begin
      if (count_inc >= {period_i, 4'b0000}) begin
        count_d = '0;
        phase_d = ~phase_q;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= 1'b0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// File: hw/rtl/psg_noise.sv
// ----------------------------------------------------------------------------
// PSG noise channel
// Rate counter and 16-bit white/periodic shift register.
// ----------------------------------------------------------------------------
module psg_noise (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  psg_pkg::period_t ctrl_i,
  input  psg_pkg::period_t tone2_period_i,
  output logic             phase_o
);
  import psg_pkg::*;

  `include "psg_tone_noise_generator_assert.svh"

  count_t           count_q, count_d;
  count_t           count_inc;
  count_t           step;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;
  logic             phase_q, phase_d;
  logic             shift;
  logic             fb;

  // Shift interval: fixed rate or borrowed from tone 2
  always_comb begin
    if (ctrl_i[1:0] == RateTone2) begin
      step = {tone2_period_i, 4'b0000};
    end else begin
      step = NoiseBase << ctrl_i[1:0];
    end
  end

  always_comb begin
    count_inc = count_q + count_t'(1);
    shift     = tick_i && (count_inc >= step);
    fb        = ctrl_i[WhiteBit] ? (lfsr_q[0] ^ lfsr_q[3]) : lfsr_q[0];
    count_d   = count_q;
    lfsr_d    = lfsr_q;
    phase_d   = phase_q;
    if (tick_i) begin
      count_d = shift ? (count_inc - step) : count_inc;
    end
    if (shift) begin
      phase_d = lfsr_q[0];
      lfsr_d  = {fb, lfsr_q[LfsrW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lfsr_q  <= LfsrW'(1);
      phase_q <= 1'b0;
    end else begin
      count_q <= count_d;
      lfsr_q  <= lfsr_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

  `PSG_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "noise LFSR reached all zeros")
  `PSG_ASSERT(a_shift_phase, shift |=> (phase_q == $past(lfsr_q[0])),
              "noise phase is not the bit shifted out")
  `PSG_ASSERT(a_idle_lfsr, !tick_i |=> $stable(lfsr_q), "noise LFSR moved without a tick")

endmodule

// File: hw/rtl/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// PSG tone/noise generator
// Three square-wave tone channels and one LFSR noise channel driven by
// tick and byte-write beats.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle, sustained, while the result channel is not
// stalled. An accepted beat is held in the input stage register; when it
// advances, the channel counters, the noise shift register and the
// period/attenuation registers take its effect, and those registers are the
// result beat, registered together with its valid flag.
// The rate is set by the single stage of counter increment and compare
// between the stage register and the channel state. A stalled result holds
// the channel state; the input stage still takes one more beat meanwhile.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  psg_in_if.sink           in_i,
  psg_out_if.source        out_o
);
  import psg_pkg::*;

  `include "psg_tone_noise_generator_assert.svh"

  logic       stg_valid_q, stg_valid_d;
  op_e        stg_op_q;
  logic [7:0] stg_port_q;
  logic [7:0] stg_data_q;
  logic       out_valid_q, out_valid_d;
  logic       stg_adv;
  logic       in_fire;
  logic       tick;
  wr_req_t    wr_req;
  period_t    period [NumChan];
  atten_t     atten  [NumChan];
  logic       phase  [NumChan];

  // Handshake: stage advances when the result slot is free or being drained
  assign stg_adv    = stg_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !stg_valid_q || stg_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_fire) begin
      stg_valid_d = 1'b1;
    end else if (stg_adv) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (stg_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_op_q   <= op_e'(in_i.operation);
      stg_port_q <= in_i.port_address;
      stg_data_q <= in_i.write_byte;
    end
  end

  // Beat dispatch
  assign tick        = stg_adv && (stg_op_q == OpTick);
  assign wr_req.en   = stg_adv && (stg_op_q == OpWrite);
  assign wr_req.port = stg_port_q;
  assign wr_req.data = stg_data_q;

  psg_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_req),
    .period_o (period),
    .atten_o  (atten)
  );

  for (genvar g = 0; g < NumTone; g++) begin : g_tone
    psg_tone u_tone (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tick_i   (tick),
      .period_i (period[g]),
      .phase_o  (phase[g])
    );
  end

  psg_noise u_noise (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .ctrl_i         (period[NumChan-1]),
    .tone2_period_i (period[NumTone-1]),
    .phase_o        (phase[NumChan-1])
  );

  // Result beat straight from channel state
  assign out_o.valid       = out_valid_q;
  assign out_o.tone0_phase = phase[0];
  assign out_o.tone1_phase = phase[1];
  assign out_o.tone2_phase = phase[2];
  assign out_o.noise_phase = phase[3];
  assign out_o.tone0_atten = atten[0];
  assign out_o.tone1_atten = atten[1];
  assign out_o.tone2_atten = atten[2];
  assign out_o.noise_atten = atten[3];

  `PSG_ASSERT(a_stg_hold, (stg_valid_q && !stg_adv) |=> stg_valid_q,
              "input stage dropped a beat")
  `PSG_ASSERT(a_in_fill, in_fire |=> stg_valid_q, "accepted beat missing from stage")
  `PSG_ASSERT(a_adv_out, stg_adv |=> out_valid_q, "advanced beat produced no result")

endmodule

// File: tb/sv/psg_tone_noise_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PSG tone/noise generator testbench
// Drives tick and byte-write beats through the input channel with bursty
// traffic, stalls the result channel on a changing pattern, and checks every
// result beat against typed levels or a cycle-free model of the tone
// counters, the noise shift register and the period/attenuation registers.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_tb;
  import psg_pkg::*;

  localparam int NoiseCh   = NumTone;
  localparam int NumRows   = 25;
  localparam int NumRandom = 1425;
  localparam int MaxReport = 10;

  // Byte fields of a latch write
  localparam logic [7:0] LatchFlag  = 8'h80;
  localparam logic [7:0] AttenSel   = 8'h10;
  localparam logic [7:0] Chan0Sel   = 8'h00;
  localparam logic [7:0] Chan1Sel   = 8'h20;
  localparam logic [7:0] Chan2Sel   = 8'h40;
  localparam logic [7:0] NoiseSel   = 8'h60;
  localparam logic [7:0] NoiseWhite = 8'h04;
  localparam logic [7:0] NoiseRate3 = 8'h03;

  // Result beat, msb first: phases then attenuations
  typedef struct packed {
    logic   tone0_phase;
    logic   tone1_phase;
    logic   tone2_phase;
    logic   noise_phase;
    atten_t tone0_atten;
    atten_t tone1_atten;
    atten_t tone2_atten;
    atten_t noise_atten;
  } levels_t;

  // Directed row; phases/attens hold the typed result when fixed is set
  typedef struct packed {
    op_e         op;
    logic [7:0]  port;
    logic [7:0]  data;
    logic        fixed;
    logic [3:0]  phases;
    logic [15:0] attens;
  } beat_row_t;

  typedef enum logic [1:0] {
    StallNone,
    StallPattern,
    StallRandom
  } stall_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psg_in_if  in_bus ();
  psg_out_if out_bus ();

  psg_tone_noise_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Model state
  period_t          period_q [NumChan];
  atten_t           atten_q  [NumChan];
  logic             phase_q  [NumChan];
  count_t           count_q  [NumChan];
  logic [LfsrW-1:0] lfsr_q;
  logic [7:0]       cmd_q;

  levels_t   levels_due [$];
  beat_row_t dir_rows [NumRows];

  int mismatches   = 0;
  int tick_total   = 0;
  int write_total  = 0;
  int tone_flips   = 0;
  int noise_shifts = 0;
  int burst_left   = 0;

  // Applies one beat to the model state and returns the levels after it
  function automatic levels_t next_levels(input op_e op, input logic [7:0] port,
                                          input logic [7:0] data);
    logic [31:0] span;
    logic [1:0]  sel;
    logic        out_bit;
    if (op == OpTick) begin
      tick_total++;
      // tone channels: toggle when the count reaches period*16
      for (int ch = 0; ch < NumTone; ch++) begin
        count_q[ch] = count_q[ch] + 1'b1;
        if (32'(count_q[ch]) >= 32'(period_q[ch]) * 32'd16) begin
          count_q[ch] = '0;
          phase_q[ch] = ~phase_q[ch];
          tone_flips++;
        end
      end
      // noise channel: fixed rate or tone 2 period
      sel = period_q[NoiseCh][1:0];
      if (sel == RateTone2) span = 32'(period_q[2]) * 32'd16;
      else                  span = 32'(NoiseBase) << sel;
      count_q[NoiseCh] = count_q[NoiseCh] + 1'b1;
      if (32'(count_q[NoiseCh]) >= span) begin
        count_q[NoiseCh] = count_t'(32'(count_q[NoiseCh]) - span);
        out_bit = lfsr_q[0];
        phase_q[NoiseCh] = out_bit;
        if (period_q[NoiseCh][WhiteBit]) lfsr_q = {out_bit ^ lfsr_q[3], lfsr_q[LfsrW-1:1]};
        else                              lfsr_q = {out_bit, lfsr_q[LfsrW-1:1]};
        noise_shifts++;
      end
    end else begin
      write_total++;
      if (data[LatchBit]) begin
        // latch byte: register update only on the write port
        sel = data[6:5];
        if (port == WritePort) begin
          if (data[TypeBit]) atten_q[sel] = data[AttenW-1:0];
          else               period_q[sel][3:0] = data[3:0];
        end
        cmd_q = data;
      end else begin
        // data byte: upper period bits of the latched channel
        sel = cmd_q[6:5];
        if (port == WritePort && !cmd_q[TypeBit]) period_q[sel][PeriodW-1:4] = data[5:0];
      end
    end
    return '{phase_q[0], phase_q[1], phase_q[2], phase_q[NoiseCh],
             atten_q[0], atten_q[1], atten_q[2], atten_q[NoiseCh]};
  endfunction

  // Sends one beat, records its expectation, then idles between bursts
  task automatic send_beat(input op_e op, input logic [7:0] port, input logic [7:0] data,
                           input logic fixed, input levels_t typed);
    levels_t due;
    int      gap;
    in_bus.valid        <= 1'b1;
    in_bus.operation    <= op;
    in_bus.port_address <= port;
    in_bus.write_byte   <= data;
    do @(posedge clk_i); while (!in_bus.ready);
    due = next_levels(op, port, data);
    levels_due.push_back(fixed ? typed : due);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Result channel stall pattern
  stall_e      stall_mode = StallNone;
  logic [15:0] stall_bits = '1;
  int          stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_e'($urandom_range(0, 2));
        stall_bits = 16'($urandom);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      stall_bits = {stall_bits[14:0], stall_bits[15]};
      case (stall_mode)
        StallNone:    out_bus.ready <= 1'b1;
        StallPattern: out_bus.ready <= stall_bits[0];
        default:      out_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    levels_t got;
    levels_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.tone0_phase, out_bus.tone1_phase, out_bus.tone2_phase,
              out_bus.noise_phase, out_bus.tone0_atten, out_bus.tone1_atten,
              out_bus.tone2_atten, out_bus.noise_atten};
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("%0t: result beat with nothing expected: phases %b%b%b%b attens %h %h %h %h",
                   $realtime, got.tone0_phase, got.tone1_phase, got.tone2_phase,
                   got.noise_phase, got.tone0_atten, got.tone1_atten, got.tone2_atten,
                   got.noise_atten);
      end else begin
        want = levels_due.pop_front();
        if (got.tone0_phase !== want.tone0_phase || got.tone1_phase !== want.tone1_phase ||
            got.tone2_phase !== want.tone2_phase || got.noise_phase !== want.noise_phase ||
            got.tone0_atten !== want.tone0_atten || got.tone1_atten !== want.tone1_atten ||
            got.tone2_atten !== want.tone2_atten || got.noise_atten !== want.noise_atten) begin
          mismatches++;
          if (mismatches <= MaxReport)
            $display("%0t: mismatch: exp phases %b%b%b%b attens %h %h %h %h, got phases %b%b%b%b attens %h %h %h %h",
                     $realtime, want.tone0_phase, want.tone1_phase, want.tone2_phase,
                     want.noise_phase, want.tone0_atten, want.tone1_atten,
                     want.tone2_atten, want.noise_atten, got.tone0_phase,
                     got.tone1_phase, got.tone2_phase, got.noise_phase,
                     got.tone0_atten, got.tone1_atten, got.tone2_atten,
                     got.noise_atten);
        end
      end
    end
  end

  // Stimulus
  initial begin
    op_e        op;
    logic [7:0] port;
    logic [7:0] data;

    for (int ch = 0; ch < NumChan; ch++) begin
      period_q[ch] = '0;
      atten_q[ch]  = '0;
      phase_q[ch]  = 1'b0;
      count_q[ch]  = '0;
    end
    lfsr_q = LfsrW'(1);
    cmd_q  = '0;

    in_bus.valid        = 1'b0;
    in_bus.operation    = OpTick;
    in_bus.port_address = '0;
    in_bus.write_byte   = '0;

    dir_rows = '{
      // data byte off the port right after reset: nothing moves
      '{OpWrite, 8'h00,     8'h00,                                1'b1, 4'b0000, 16'h0000},
      // full attenuation on each channel in turn
      '{OpWrite, WritePort, LatchFlag | Chan0Sel | AttenSel | 8'h0F, 1'b1, 4'b0000, 16'hF000},
      '{OpWrite, WritePort, LatchFlag | Chan1Sel | AttenSel | 8'h0F, 1'b1, 4'b0000, 16'hFF00},
      '{OpWrite, WritePort, LatchFlag | Chan2Sel | AttenSel | 8'h0F, 1'b1, 4'b0000, 16'hFFF0},
      '{OpWrite, WritePort, LatchFlag | NoiseSel | AttenSel | 8'h0F, 1'b1, 4'b0000, 16'hFFFF},
      // data byte with attenuation latched keeps the nibble
      '{OpWrite, WritePort, 8'h3F,                                1'b1, 4'b0000, 16'hFFFF},
      // latch on another port only moves the latched command
      '{OpWrite, 8'h12,     LatchFlag | Chan0Sel | AttenSel,      1'b1, 4'b0000, 16'hFFFF},
      '{OpWrite, WritePort, LatchFlag | Chan0Sel | AttenSel,      1'b1, 4'b0000, 16'h0FFF},
      // zero tone periods toggle on every tick
      '{OpTick,  8'h00,     8'h00,                                1'b1, 4'b1110, 16'h0FFF},
      '{OpTick,  8'hFF,     8'hFF,                                1'b1, 4'b0000, 16'h0FFF},
      // largest tone period, bit 6 of the data byte ignored
      '{OpWrite, WritePort, LatchFlag | Chan0Sel | 8'h0F,         1'b0, 4'b0000, 16'h0000},
      '{OpWrite, WritePort, 8'h3F,                                1'b0, 4'b0000, 16'h0000},
      '{OpWrite, WritePort, 8'h7F,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      // noise on tone 2 period of zero: shifts every tick, periodic then white
      '{OpWrite, WritePort, LatchFlag | NoiseSel | NoiseRate3,    1'b0, 4'b0000, 16'h0000},
      '{OpWrite, WritePort, 8'h00,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      '{OpWrite, WritePort, LatchFlag | NoiseSel | NoiseWhite | NoiseRate3,
                                                                  1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000},
      // nonzero tone 2 period, then a stray data byte off the port
      '{OpWrite, WritePort, LatchFlag | Chan2Sel | 8'h01,         1'b0, 4'b0000, 16'h0000},
      '{OpWrite, 8'hFF,     8'h55,                                1'b0, 4'b0000, 16'h0000},
      '{OpTick,  8'h00,     8'h00,                                1'b0, 4'b0000, 16'h0000}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < NumRows; i++)
      send_beat(dir_rows[i].op, dir_rows[i].port, dir_rows[i].data, dir_rows[i].fixed,
                levels_t'({dir_rows[i].phases, dir_rows[i].attens}));

    // random part: mostly ticks, writes biased to the write port and short periods
    for (int i = 0; i < NumRandom; i++) begin
      op   = ($urandom_range(0, 9) < 7) ? OpTick : OpWrite;
      port = 8'($urandom);
      data = 8'($urandom);
      if (op == OpWrite) begin
        if ($urandom_range(0, 99) < 85) port = WritePort;
        case ($urandom_range(0, 3))
          0, 1:    data = LatchFlag | 8'($urandom_range(0, 127));
          2:       data = {1'b0, 1'($urandom), 4'h0, 2'($urandom)};
          default: data = 8'($urandom);
        endcase
      end
      send_beat(op, port, data, 1'b0, '0);
    end
    in_bus.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d ticks and %0d byte writes sent", tick_total, write_total);
    $display("summary: %0d tone toggles and %0d noise shifts predicted", tone_flips,
             noise_shifts);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("timeout with %0d results outstanding", levels_due.size());
    $display("tb: failure");
    $finish;
  end

endmodule
